// ----- design/dcfm_pkg.sv -----
// ----------------------------------------------------------------------------
// dcfm_pkg
// Shared types, codes and defaults for the DMA channel fault monitor.
// ----------------------------------------------------------------------------
package dcfm_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 8;

  localparam logic [31:0] TIMEOUT_MS_RST  = 32'd1000;
  localparam logic [7:0]  ERR_THRESH_RST  = 8'd5;
  localparam logic [3:0]  MAX_RETRIES_RST = 4'd3;
  localparam logic        MON_EN_RST      = 1'b1;

  localparam logic [7:0]  ERR_CNT_MAX     = 8'hFF;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_COMPLETE = 3'd1,
    OP_IRQ      = 3'd2,
    OP_SCAN     = 3'd3,
    OP_RESET    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_LOCKED    = 3'd2,
    ST_THRESHOLD = 3'd3,
    ST_RETRIES   = 3'd4,
    ST_TIMEOUT   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_TIMEOUT_MS  = 2'd0,
    CFG_ERR_THRESH  = 2'd1,
    CFG_MAX_RETRIES = 2'd2,
    CFG_MON_EN      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } seq_state_t;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic ready;   // able to take a new event
    logic exec;    // handle the captured event
    logic scan;    // run one scan step at the current channel index
    logic load;    // move the finished result into the output register
  } seq_ctrl_t;

endpackage

// ----- design/dma_channel_fault_monitor.sv -----
// ----------------------------------------------------------------------------
// dma_channel_fault_monitor
// Per-channel DMA fault monitor: one event in, one status transfer out.
// ----------------------------------------------------------------------------
// A plain event keeps the block busy through three steps: accept, execute
// and hand-off. Its result is loaded into the output register at the
// hand-off. A timeout scan with monitoring on adds a scan step per channel,
// because one shared elapsed-time compare unit visits the channels one per
// cycle. The hand-off waits while an untaken result still fills the output
// register. The input side is ready again as soon as the result sits in the
// output register, so one finished result may wait while the next event is
// taken. Channel state (last activity, error and retry counts, lock bit) and
// both wrapping totals clear on reset.
module dma_channel_fault_monitor #(
  parameter int unsigned NUM_CHANNELS = dcfm_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Event input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] op
  // [3:0] channel, [4] success, [5] hw_error, [37:6] now_ms,
  // [45:38] active_mask, [47:46] zero
  input  logic [47:0] in_tdata,
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // [2:0] status
  // [7:0] stop_mask, [8] restart, [9] channel_safe, [41:10] error total,
  // [73:42] timeout total, [79:74] zero
  output logic [79:0] out_tdata,
  // Configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration
  logic [31:0] timeout_ms_r;
  logic [7:0]  err_thresh_r;
  logic [3:0]  max_retries_r;
  logic        mon_en_r;

  // Captured event
  dcfm_pkg::op_t          op_r;
  logic [3:0]             ch_r;
  logic                   success_r;
  logic                   hw_error_r;
  logic [31:0]            now_r;
  logic [NUM_CHANNELS-1:0] active_r;

  // Channel state
  logic [31:0] last_act_r  [NUM_CHANNELS];
  logic [7:0]  err_cnt_r   [NUM_CHANNELS];
  logic [3:0]  retry_cnt_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] locked_r;
  logic [31:0] err_total_r;
  logic [31:0] tmo_total_r;

  // Result under construction
  dcfm_pkg::status_t       status_r;
  logic [NUM_CHANNELS-1:0] stop_r;
  logic                    restart_r;
  logic                    out_valid_r;

  dcfm_pkg::seq_ctrl_t ctrl;
  logic [IDX_W-1:0]    scan_idx;
  logic                in_fire;
  logic                out_free;
  logic                scan_go;
  logic                expired;
  logic                ch_valid;
  logic [IDX_W-1:0]    ch_idx;
  logic [7:0]          err_inc;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = ctrl.ready;
  assign out_free  = !out_valid_r || out_tready;
  assign scan_go   = (op_r == dcfm_pkg::OP_SCAN) && mon_en_r;
  assign ch_valid  = ({1'b0, ch_r} < 5'(NUM_CHANNELS));
  assign ch_idx    = ch_r[IDX_W-1:0];
  assign err_inc   = (err_cnt_r[ch_idx] == dcfm_pkg::ERR_CNT_MAX) ?
                     dcfm_pkg::ERR_CNT_MAX : err_cnt_r[ch_idx] + 8'd1;

  dcfm_seq #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .scan_go (scan_go),
    .out_free(out_free),
    .ctrl    (ctrl),
    .scan_idx(scan_idx)
  );

  dcfm_elapsed u_elapsed (
    .now_ms  (now_r),
    .last_ms (last_act_r[scan_idx]),
    .limit_ms(timeout_ms_r),
    .expired (expired)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ms_r  <= dcfm_pkg::TIMEOUT_MS_RST;
      err_thresh_r  <= dcfm_pkg::ERR_THRESH_RST;
      max_retries_r <= dcfm_pkg::MAX_RETRIES_RST;
      mon_en_r      <= dcfm_pkg::MON_EN_RST;
    end else if (cfg_we) begin
      unique case (dcfm_pkg::cfg_idx_t'(cfg_addr))
        dcfm_pkg::CFG_TIMEOUT_MS:  timeout_ms_r  <= cfg_wdata;
        dcfm_pkg::CFG_ERR_THRESH:  err_thresh_r  <= cfg_wdata[7:0];
        dcfm_pkg::CFG_MAX_RETRIES: max_retries_r <= cfg_wdata[3:0];
        dcfm_pkg::CFG_MON_EN:      mon_en_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Event capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= dcfm_pkg::op_t'(in_tuser);
      ch_r       <= in_tdata[3:0];
      success_r  <= in_tdata[4];
      hw_error_r <= in_tdata[5];
      now_r      <= in_tdata[37:6];
      active_r   <= in_tdata[38 +: NUM_CHANNELS];
    end
  end

  // Channel state and result build-up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_act_r[i]  <= '0;
        err_cnt_r[i]   <= '0;
        retry_cnt_r[i] <= '0;
      end
      locked_r    <= '0;
      err_total_r <= '0;
      tmo_total_r <= '0;
    end else if (ctrl.exec) begin
      stop_r <= '0;
      unique case (op_r)
        dcfm_pkg::OP_START: begin
          restart_r <= 1'b0;
          if (!ch_valid) begin
            status_r <= dcfm_pkg::ST_INVALID;
          end else if (locked_r[ch_idx]) begin
            status_r <= dcfm_pkg::ST_LOCKED;
          end else begin
            status_r           <= dcfm_pkg::ST_OK;
            last_act_r[ch_idx] <= now_r;
          end
        end
        dcfm_pkg::OP_COMPLETE: begin
          restart_r <= 1'b0;
          if (!ch_valid) begin
            status_r <= dcfm_pkg::ST_INVALID;
          end else if (!success_r) begin
            err_cnt_r[ch_idx] <= err_inc;
            err_total_r       <= err_total_r + 32'd1;
            if (err_inc >= err_thresh_r) begin
              locked_r[ch_idx] <= 1'b1;
              status_r         <= dcfm_pkg::ST_THRESHOLD;
            end else begin
              status_r <= dcfm_pkg::ST_OK;
            end
          end else begin
            status_r <= dcfm_pkg::ST_OK;
          end
        end
        dcfm_pkg::OP_IRQ: begin
          if (!ch_valid) begin
            status_r  <= dcfm_pkg::ST_INVALID;
            restart_r <= 1'b0;
          end else begin
            last_act_r[ch_idx] <= now_r;
            if (hw_error_r) begin
              err_cnt_r[ch_idx] <= err_inc;
              err_total_r       <= err_total_r + 32'd1;
              if (err_inc >= err_thresh_r) begin
                locked_r[ch_idx] <= 1'b1;
                status_r         <= dcfm_pkg::ST_THRESHOLD;
                restart_r        <= 1'b0;
              end else if (retry_cnt_r[ch_idx] < max_retries_r) begin
                retry_cnt_r[ch_idx] <= retry_cnt_r[ch_idx] + 4'd1;
                status_r            <= dcfm_pkg::ST_OK;
                restart_r           <= 1'b1;
              end else begin
                status_r  <= dcfm_pkg::ST_RETRIES;
                restart_r <= 1'b0;
              end
            end else begin
              retry_cnt_r[ch_idx] <= '0;
              status_r            <= dcfm_pkg::ST_OK;
              restart_r           <= 1'b0;
            end
          end
        end
        dcfm_pkg::OP_RESET: begin
          restart_r <= 1'b0;
          if (!ch_valid) begin
            status_r <= dcfm_pkg::ST_INVALID;
          end else begin
            status_r            <= dcfm_pkg::ST_OK;
            last_act_r[ch_idx]  <= '0;
            err_cnt_r[ch_idx]   <= '0;
            retry_cnt_r[ch_idx] <= '0;
            locked_r[ch_idx]    <= 1'b0;
          end
        end
        default: begin
          // scan work runs in the sequencer's scan steps
          status_r  <= dcfm_pkg::ST_OK;
          restart_r <= 1'b0;
        end
      endcase
    end else if (ctrl.scan) begin
      // Stop an active channel whose time has run out and restart its clock
      if (active_r[scan_idx] && expired) begin
        tmo_total_r          <= tmo_total_r + 32'd1;
        stop_r[scan_idx]     <= 1'b1;
        last_act_r[scan_idx] <= now_r;
        status_r             <= dcfm_pkg::ST_TIMEOUT;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_tuser <= status_r;
      out_tdata <= {6'd0, tmo_total_r, err_total_r,
                    ch_valid && !locked_r[ch_idx], restart_r, 8'(stop_r)};
    end
  end

  assign out_tvalid = out_valid_r;

  // A taken event keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input ready right after an accepted event");

  // Stopped channels only come with a timeout status
  a_stop_means_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] != 8'd0) |-> out_tuser == dcfm_pkg::ST_TIMEOUT)
    else $error("stop mask set without timeout status");

  // A restart request only comes with an ok status
  a_restart_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> (out_tuser == dcfm_pkg::ST_OK))
    else $error("restart requested with non-ok status");

endmodule

// ----- design/dcfm_elapsed.sv -----
// ----------------------------------------------------------------------------
// dcfm_elapsed
// Shared elapsed-time unit: wrapping subtract and compare against the limit.
// ----------------------------------------------------------------------------
module dcfm_elapsed (
  input  logic [31:0] now_ms,
  input  logic [31:0] last_ms,
  input  logic [31:0] limit_ms,
  output logic        expired
);

  logic [31:0] elapsed;

  // Modulo 2^32 difference
  assign elapsed = now_ms - last_ms;
  assign expired = (elapsed >= limit_ms);

endmodule

// ----- design/dcfm_seq.sv -----
// ----------------------------------------------------------------------------
// dcfm_seq
// Event sequencer: capture, execute, step the scan over channels, hand off.
// ----------------------------------------------------------------------------
module dcfm_seq #(
  parameter int unsigned NUM_CHANNELS = dcfm_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                scan_go,
  input  logic                out_free,
  output dcfm_pkg::seq_ctrl_t ctrl,
  output logic [IDX_W-1:0]    scan_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  dcfm_pkg::seq_state_t state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dcfm_pkg::S_IDLE: if (in_fire) state_nxt = dcfm_pkg::S_EXEC;
      dcfm_pkg::S_EXEC: state_nxt = scan_go ? dcfm_pkg::S_SCAN : dcfm_pkg::S_DONE;
      dcfm_pkg::S_SCAN: if (idx_r == LAST_IDX) state_nxt = dcfm_pkg::S_DONE;
      dcfm_pkg::S_DONE: if (out_free) state_nxt = dcfm_pkg::S_IDLE;
      default:          state_nxt = dcfm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (state_r == dcfm_pkg::S_EXEC) begin
      idx_nxt = '0;
    end else if (state_r == dcfm_pkg::S_SCAN && idx_r != LAST_IDX) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    ctrl.ready = (state_r == dcfm_pkg::S_IDLE);
    ctrl.exec  = (state_r == dcfm_pkg::S_EXEC);
    ctrl.scan  = (state_r == dcfm_pkg::S_SCAN);
    ctrl.load  = (state_r == dcfm_pkg::S_DONE) && out_free;
  end

  assign scan_idx = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcfm_pkg::S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
